[hdl/assert_macros.svh]
// Assertion macros shared by the classifier RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MNNC_ASSERT_IMPLY(name, ck, rs, pre, post, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MNNC_ASSERT_NEXT(name, ck, rs, pre, post, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/mnnc_pkg.sv]
// Types and constants of the nearest-neighbor classifier: beat payloads,
// opcodes, class codes and register indexes. No dependencies.
`default_nettype none

package mnnc_pkg;

  localparam int CNT_W     = 16;
  localparam int DIST_W    = 39;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 9;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  localparam logic [7:0] WORD_COUNT_RESET  = 8'd128;
  localparam logic [8:0] ENTRY_COUNT_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b1;

  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_LABEL    = 3'd1;
  localparam logic [2:0] OP_MASK     = 3'd2;
  localparam logic [2:0] OP_CLASSIFY = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_ONE  = 2'd1;
  localparam logic [1:0] CLASS_TWO  = 2'd2;
  localparam logic [1:0] CLASS_BAD  = 2'd3;

  localparam logic RES_CLASSIFIED = 1'b0;
  localparam logic RES_NOT_TEST   = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  entry_index;
    logic [6:0]  word_index;
    logic [15:0] feature_value;
    logic [1:0]  class_label;
    logic        is_test;
    logic        mask_bit;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [1:0]        predicted_class;
    logic [1:0]        expected_class;
    logic [DIST_W-1:0] min_distance;
    logic [CNT_W-1:0]  positives_count;
    logic [CNT_W-1:0]  negatives_count;
    logic [CNT_W-1:0]  true_pos_count;
    logic [CNT_W-1:0]  true_neg_count;
  } out_item_t;

  typedef struct packed {
    logic       is_test;
    logic [1:0] class_label;
  } entry_info_t;

endpackage

`default_nettype wire

[hdl/masked_nearest_neighbor_classifier.sv]
// Masked one-nearest-neighbor classifier: entry/feature/mask stores, scan
// sequencer and one shared squared-difference accumulate unit.
// Depends on mnnc_pkg and assert_macros.svh.
`default_nettype none

// After reset the block sweeps its label and mask stores to zero over
// max(MAX_ENTRIES, MAX_WORDS) addresses (256 by default) and holds in_stall
// high meanwhile; configuration writes are taken at any time. Load, label,
// mask and clear-count beats complete on acceptance. After the accept and the
// query lookup, a classify beat whose query is an in-range test entry scans
// entries 0 to min(entry_count, MAX_ENTRIES)-1 through one feature-memory
// read pair and one multiplier; each training entry gets a word pass (none
// when no words are in use), other entries are skipped. The result hand-off
// waits while a stalled result beat still sits in the output register; one
// result beat follows, and the next beat is taken as soon as it is registered.
module masked_nearest_neighbor_classifier #(
  parameter int MAX_ENTRIES  = 256,
  parameter int MAX_WORDS    = 128,
  parameter int FEATURE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [mnnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mnnc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire mnnc_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output mnnc_pkg::out_item_t                 out_data
);
  import mnnc_pkg::*;

  localparam int EAW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int WAW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int ECW    = $clog2(MAX_ENTRIES + 1);
  localparam int WCW    = $clog2(MAX_WORDS + 1);
  localparam int FB     = FEATURE_BITS;
  localparam int ACC_W  = 2 * FEATURE_BITS + WCW;
  localparam int FDEPTH = MAX_ENTRIES * (2 ** WAW);
  localparam int CLR_N  = (MAX_ENTRIES > MAX_WORDS) ? MAX_ENTRIES : MAX_WORDS;
  localparam int CLW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_QUERY  = 4'd2;
  localparam logic [3:0] ST_ENT_RD = 4'd3;
  localparam logic [3:0] ST_ENT_CK = 4'd4;
  localparam logic [3:0] ST_WORDS  = 4'd5;
  localparam logic [3:0] ST_CMP    = 4'd6;
  localparam logic [3:0] ST_FINISH = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  // stores
  logic [FB-1:0] feature_mem [FDEPTH];
  entry_info_t   info_mem [MAX_ENTRIES];
  logic          mask_mem [MAX_WORDS];

  logic [3:0]     state;
  logic [CLW-1:0] clr;
  logic [7:0]     word_count;
  logic [8:0]     entry_count;

  logic [EAW-1:0] q_idx;
  logic           q_ok;
  logic [ECW-1:0] j;
  logic [WAW-1:0] w;
  logic           issue_on;
  logic [1:0]     cand_class;
  logic [1:0]     pred;
  logic [1:0]     expc;
  logic           res_status;
  logic           found;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] best;

  logic [CNT_W-1:0] cnt_p;
  logic [CNT_W-1:0] cnt_n;
  logic [CNT_W-1:0] cnt_tp;
  logic [CNT_W-1:0] cnt_tn;

  // read data and arithmetic pipeline
  entry_info_t      info_rd;
  logic [FB-1:0]    feat_a;
  logic [FB-1:0]    feat_b;
  logic             mask_rd;
  logic             s1_v, s1_last;
  logic [FB-1:0]    diff;
  logic             s2_v, s2_last;
  logic [2*FB-1:0]  sq;
  logic             s3_v, s3_last;

  logic [ECW-1:0] n_ent;
  logic [WCW-1:0] n_words;
  logic           accept;
  logic           ent_last;
  logic           w_last;
  logic           out_free;
  logic [EAW-1:0] info_addr;
  logic           info_we;
  logic [EAW-1:0] info_wa;
  entry_info_t    info_wd;
  logic           mask_we;
  logic [WAW-1:0] mask_wa;
  logic           mask_wd;
  logic           feat_we;
  logic [DIST_W-1:0] dist_sat;

  always_comb begin
    n_ent   = (32'(entry_count) > MAX_ENTRIES) ? ECW'(MAX_ENTRIES) : ECW'(entry_count);
    n_words = (32'(word_count) > MAX_WORDS) ? WCW'(MAX_WORDS) : WCW'(word_count);
    accept   = in_valid && !in_stall;
    ent_last = ((j + ECW'(1)) == n_ent);
    w_last   = ((WCW'(w) + WCW'(1)) == n_words);
    out_free = !out_valid || !out_stall;
    info_addr = (state == ST_IDLE) ? EAW'(in_data.entry_index) : j[EAW-1:0];
    dist_sat = (64'(best) > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(best);
  end

  assign in_stall = (state != ST_IDLE);

  // store write ports
  always_comb begin
    info_we = 1'b0;
    info_wa = EAW'(in_data.entry_index);
    info_wd = '{is_test: in_data.is_test,
                class_label: (in_data.class_label == CLASS_BAD) ? CLASS_NONE
                                                                 : in_data.class_label};
    mask_we = 1'b0;
    mask_wa = WAW'(in_data.word_index);
    mask_wd = in_data.mask_bit;
    feat_we = 1'b0;
    if (state == ST_CLEAR) begin
      info_we = (32'(clr) < MAX_ENTRIES);
      info_wa = clr[EAW-1:0];
      info_wd = '{is_test: 1'b0, class_label: CLASS_NONE};
      mask_we = (32'(clr) < MAX_WORDS);
      mask_wa = clr[WAW-1:0];
      mask_wd = 1'b0;
    end else if (accept) begin
      info_we = (in_data.opcode == OP_LABEL) && (32'(in_data.entry_index) < MAX_ENTRIES);
      mask_we = (in_data.opcode == OP_MASK) && (32'(in_data.word_index) < MAX_WORDS);
      feat_we = (in_data.opcode == OP_LOAD) && (32'(in_data.entry_index) < MAX_ENTRIES)
                && (32'(in_data.word_index) < MAX_WORDS);
    end
  end

  always_ff @(posedge clk) begin
    if (feat_we) begin
      feature_mem[{EAW'(in_data.entry_index), WAW'(in_data.word_index)}]
        <= FB'(in_data.feature_value);
    end
    feat_a <= feature_mem[{q_idx, w}];
    feat_b <= feature_mem[{j[EAW-1:0], w}];
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_wa] <= info_wd;
    end
    info_rd <= info_mem[info_addr];
  end

  always_ff @(posedge clk) begin
    if (mask_we) begin
      mask_mem[mask_wa] <= mask_wd;
    end
    mask_rd <= mask_mem[w];
  end

  // shared squared-difference unit
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= (state == ST_WORDS) && issue_on;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
    s1_last <= w_last;
    s2_last <= s1_last;
    s3_last <= s2_last;
    diff <= !mask_rd ? '0 : (feat_a > feat_b) ? (feat_a - feat_b) : (feat_b - feat_a);
    sq   <= diff * diff;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count  <= WORD_COUNT_RESET;
      entry_count <= ENTRY_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WORD_COUNT:  word_count  <= cfg_data[7:0];
        REG_ENTRY_COUNT: entry_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      issue_on  <= 1'b0;
      out_valid <= 1'b0;
      cnt_p     <= '0;
      cnt_n     <= '0;
      cnt_tp    <= '0;
      cnt_tn    <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + CLW'(1);
          if (32'(clr) == CLR_N - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (in_data.opcode)
              OP_CLASSIFY: begin
                q_idx <= EAW'(in_data.entry_index);
                q_ok  <= (32'(in_data.entry_index) < 32'(n_ent));
                j     <= '0;
                state <= ST_QUERY;
              end
              OP_CLEAR: begin
                cnt_p  <= '0;
                cnt_n  <= '0;
                cnt_tp <= '0;
                cnt_tn <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_QUERY: begin
          found <= 1'b0;
          pred  <= CLASS_NONE;
          best  <= '0;
          if (q_ok && info_rd.is_test) begin
            res_status <= RES_CLASSIFIED;
            expc       <= info_rd.class_label;
            state      <= ST_ENT_CK;
          end else begin
            res_status <= RES_NOT_TEST;
            expc       <= CLASS_NONE;
            state      <= ST_DONE;
          end
        end
        ST_ENT_RD: begin
          state <= ST_ENT_CK;
        end
        ST_ENT_CK: begin
          if (info_rd.is_test || info_rd.class_label == CLASS_NONE) begin
            j     <= j + ECW'(1);
            state <= ent_last ? ST_FINISH : ST_ENT_RD;
          end else begin
            cand_class <= info_rd.class_label;
            acc        <= '0;
            w          <= '0;
            if (n_words == '0) begin
              state <= ST_CMP;
            end else begin
              issue_on <= 1'b1;
              state    <= ST_WORDS;
            end
          end
        end
        ST_WORDS: begin
          if (issue_on) begin
            w <= w + WAW'(1);
            if (w_last) begin
              issue_on <= 1'b0;
            end
          end
          if (s3_v) begin
            acc <= acc + ACC_W'(sq);
            if (s3_last) begin
              state <= ST_CMP;
            end
          end
        end
        ST_CMP: begin
          if (!found || acc < best) begin
            found <= 1'b1;
            best  <= acc;
            pred  <= cand_class;
          end
          j     <= j + ECW'(1);
          state <= ent_last ? ST_FINISH : ST_ENT_RD;
        end
        ST_FINISH: begin
          if (expc == CLASS_ONE) begin
            if (cnt_p != CNT_MAX) cnt_p <= cnt_p + CNT_W'(1);
            if (pred == CLASS_ONE && cnt_tp != CNT_MAX) cnt_tp <= cnt_tp + CNT_W'(1);
          end else if (expc == CLASS_TWO) begin
            if (cnt_n != CNT_MAX) cnt_n <= cnt_n + CNT_W'(1);
            if (pred == CLASS_TWO && cnt_tn != CNT_MAX) cnt_tn <= cnt_tn + CNT_W'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_data.status          <= res_status;
      out_data.predicted_class <= pred;
      out_data.expected_class  <= expc;
      out_data.min_distance    <= found ? dist_sat : '0;
      out_data.positives_count <= cnt_p;
      out_data.negatives_count <= cnt_n;
      out_data.true_pos_count  <= cnt_tp;
      out_data.true_neg_count  <= cnt_tn;
    end
  end

  `include "assert_macros.svh"

  `MNNC_ASSERT_IMPLY(a_true_le_total, clk, rst, 1'b1, (cnt_tp <= cnt_p) && (cnt_tn <= cnt_n), "true count exceeds class count")
  `MNNC_ASSERT_IMPLY(a_result_from_done, clk, rst, $rose(out_valid), $past(state) == ST_DONE, "result beat raised outside wrap-up")
  `MNNC_ASSERT_IMPLY(a_found_has_class, clk, rst, (state == ST_DONE) && found, pred != CLASS_NONE, "nearest entry carries no class")
  `MNNC_ASSERT_NEXT(a_result_carries_pred, clk, rst, (state == ST_DONE) && out_free, out_valid && (out_data.predicted_class == $past(pred)), "result beat lost the prediction")

endmodule

`default_nettype wire
